// ===== sv/segx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package segx_pkg;

	// Result width of cross_x and cross_y
	localparam int OUT_BITS = 24;

	typedef enum logic [1:0] {
		ST_HIT      = 2'd0,
		ST_PARALLEL = 2'd1,
		ST_OUTSIDE  = 2'd2
	} status_t;

	// Control that rides alongside the data path
	typedef struct packed {
		logic    valid;
		status_t status;
	} ctl_t;

endpackage

`default_nettype wire

// ===== sv/segx_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Differences, cross products, determinant, exact box test, numerators.
module segx_front #(
	parameter int C  = 12,
	parameter int DW = 2 * C + 3,
	parameter int NW = DW + C + 2
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   en,
	input  wire                   in_valid,
	input  wire  signed [C-1:0]   ax0,
	input  wire  signed [C-1:0]   ay0,
	input  wire  signed [C-1:0]   ax1,
	input  wire  signed [C-1:0]   ay1,
	input  wire  signed [C-1:0]   bx0,
	input  wire  signed [C-1:0]   by0,
	input  wire  signed [C-1:0]   bx1,
	input  wire  signed [C-1:0]   by1,
	output segx_pkg::ctl_t        ctl,
	output logic [DW-1:0]         det_mag,
	output logic [NW-1:0]         nx_mag,
	output logic                  nx_neg,
	output logic [NW-1:0]         ny_mag,
	output logic                  ny_neg
);
	import segx_pkg::*;

	localparam int PW = 2 * C + 2;

	logic                  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [C-1:0]   ax_s1, ay_s1, ax_s2, ay_s2, ax_s3, ay_s3, ax_s4, ay_s4;
	logic signed [C:0]     rx_s1, ry_s1, sx_s1, sy_s1, ex_s1, ey_s1;
	logic signed [C:0]     rx_s2, ry_s2, rx_s3, ry_s3, rx_s4, ry_s4;
	logic signed [PW-1:0]  p_rsy_s2, p_rysx_s2, p_esy_s2, p_eysx_s2, p_ery_s2, p_eyrx_s2;
	logic signed [DW-1:0]  det_s3, tn_s3, un_s3;
	logic signed [DW-1:0]  det_s4, tn_s4, un_s4;
	logic                  par_s4;
	status_t               st_s5, st_s6;
	logic signed [C+DW-1:0]   mxa_s5, mya_s5;
	logic signed [DW+C:0]     mxt_s5, myt_s5;
	logic [DW-1:0]         det_s5, det_s6;
	logic signed [NW-1:0]  nx_s6, ny_s6;
	logic signed [NW-1:0]  nx_sum, ny_sum;
	status_t               st_next;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Classify the crossing against both segments
	always_comb begin
		if (par_s4)
			st_next = ST_PARALLEL;
		else if (tn_s4 < 0 || tn_s4 > det_s4 || un_s4 < 0 || un_s4 > det_s4)
			st_next = ST_OUTSIDE;
		else
			st_next = ST_HIT;
	end

	assign nx_sum = NW'(mxa_s5) + NW'(mxt_s5);
	assign ny_sum = NW'(mya_s5) + NW'(myt_s5);

	// Data stages
	always_ff @(posedge clk) begin
		if (en) begin
			// direction and offset vectors
			ax_s1 <= ax0;
			ay_s1 <= ay0;
			rx_s1 <= (C+1)'(ax1) - (C+1)'(ax0);
			ry_s1 <= (C+1)'(ay1) - (C+1)'(ay0);
			sx_s1 <= (C+1)'(bx1) - (C+1)'(bx0);
			sy_s1 <= (C+1)'(by1) - (C+1)'(by0);
			ex_s1 <= (C+1)'(bx0) - (C+1)'(ax0);
			ey_s1 <= (C+1)'(by0) - (C+1)'(ay0);
			// cross products
			ax_s2     <= ax_s1;
			ay_s2     <= ay_s1;
			rx_s2     <= rx_s1;
			ry_s2     <= ry_s1;
			p_rsy_s2  <= rx_s1 * sy_s1;
			p_rysx_s2 <= ry_s1 * sx_s1;
			p_esy_s2  <= ex_s1 * sy_s1;
			p_eysx_s2 <= ey_s1 * sx_s1;
			p_ery_s2  <= ex_s1 * ry_s1;
			p_eyrx_s2 <= ey_s1 * rx_s1;
			// determinant and parameter numerators
			ax_s3  <= ax_s2;
			ay_s3  <= ay_s2;
			rx_s3  <= rx_s2;
			ry_s3  <= ry_s2;
			det_s3 <= DW'(p_rsy_s2) - DW'(p_rysx_s2);
			tn_s3  <= DW'(p_esy_s2) - DW'(p_eysx_s2);
			un_s3  <= DW'(p_ery_s2) - DW'(p_eyrx_s2);
			// make the determinant positive
			ax_s4  <= ax_s3;
			ay_s4  <= ay_s3;
			rx_s4  <= rx_s3;
			ry_s4  <= ry_s3;
			par_s4 <= (det_s3 == '0);
			det_s4 <= det_s3[DW-1] ? -det_s3 : det_s3;
			tn_s4  <= det_s3[DW-1] ? -tn_s3 : tn_s3;
			un_s4  <= det_s3[DW-1] ? -un_s3 : un_s3;
			// status and numerator products
			st_s5  <= st_next;
			det_s5 <= det_s4;
			mxa_s5 <= ax_s4 * det_s4;
			mya_s5 <= ay_s4 * det_s4;
			mxt_s5 <= tn_s4 * rx_s4;
			myt_s5 <= tn_s4 * ry_s4;
			// numerator sums
			st_s6  <= st_s5;
			det_s6 <= det_s5;
			nx_s6  <= nx_sum;
			ny_s6  <= ny_sum;
		end
	end

	assign ctl.valid  = v_s6;
	assign ctl.status = st_s6;
	assign det_mag    = det_s6;
	assign nx_neg     = nx_s6[NW-1];
	assign ny_neg     = ny_s6[NW-1];
	assign nx_mag     = nx_s6[NW-1] ? NW'(-nx_s6) : NW'(nx_s6);
	assign ny_mag     = ny_s6[NW-1] ? NW'(-ny_s6) : NW'(ny_s6);

endmodule

`default_nettype wire

// ===== sv/segx_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider: one quotient bit per stage of (M << F) / D.
module segx_div #(
	parameter int C  = 12,
	parameter int F  = 12,
	parameter int DW = 2 * C + 3,
	parameter int NW = DW + C + 2,
	parameter int QB = C + F
) (
	input  wire              clk,
	input  wire              en,
	input  wire  [NW-1:0]    m,
	input  wire              neg_in,
	input  wire  [DW-1:0]    d,
	output logic [QB-1:0]    q,
	output logic             neg_out
);
	localparam int RW = DW + 1;

	logic [RW-1:0] rem_s [0:QB];
	logic [QB-1:0] low_s [0:QB];
	logic [QB-1:0] quo_s [0:QB];
	logic [DW-1:0] den_s [0:QB];
	logic          neg_s [0:QB];

	// Load: top part of the shifted numerator starts the remainder
	assign rem_s[0] = RW'(m >> C);
	assign low_s[0] = QB'(m[C-1:0]) << F;
	assign quo_s[0] = '0;
	assign den_s[0] = d;
	assign neg_s[0] = neg_in;

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [RW:0] trial;
		logic        take;

		assign trial = {rem_s[k], low_s[k][QB-1]};
		assign take  = (trial >= (RW+1)'(den_s[k]));

		// Subtract when the divisor fits, shift in the quotient bit
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? RW'(trial - (RW+1)'(den_s[k])) : RW'(trial);
				low_s[k+1] <= low_s[k] << 1;
				quo_s[k+1] <= {quo_s[k][QB-2:0], take};
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	assign q       = quo_s[QB];
	assign neg_out = neg_s[QB];

endmodule

`default_nettype wire

// ===== sv/segment_intersection.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel | Signals                               | Beat
// --------+---------------------------------------+------------------------------
// in      | in_valid, in_stall, 8 endpoint fields | one pair of segments
// out     | out_valid, out_stall, status, x, y    | one crossing result
//
// One beat in per cycle unless a stalled output holds the pipeline;
// six front stages, one divider stage per quotient bit, one output stage.
// The divider's bit-per-stage chain sets the depth.
// arst_n clears all valid bits; data registers are not reset.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
module segment_intersection #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 12
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire  signed [COORD_BITS-1:0] a_start_x,
	input  wire  signed [COORD_BITS-1:0] a_start_y,
	input  wire  signed [COORD_BITS-1:0] a_end_x,
	input  wire  signed [COORD_BITS-1:0] a_end_y,
	input  wire  signed [COORD_BITS-1:0] b_start_x,
	input  wire  signed [COORD_BITS-1:0] b_start_y,
	input  wire  signed [COORD_BITS-1:0] b_end_x,
	input  wire  signed [COORD_BITS-1:0] b_end_y,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [1:0]                   status,
	output logic signed [segx_pkg::OUT_BITS-1:0] cross_x,
	output logic signed [segx_pkg::OUT_BITS-1:0] cross_y
);
	import segx_pkg::*;

	localparam int C  = COORD_BITS;
	localparam int DW = 2 * C + 3;
	localparam int NW = DW + C + 2;
	localparam int QB = C + FRAC_BITS;

	logic              en;
	ctl_t              ctl_f;
	ctl_t              ctl_s [0:QB];
	logic [DW-1:0]     det_mag;
	logic [NW-1:0]     nx_mag, ny_mag;
	logic              nx_neg, ny_neg;
	logic [QB-1:0]     qx, qy;
	logic              qx_neg, qy_neg;
	logic signed [QB:0] sx, sy;
	status_t           st_q;
	logic              ov_q;
	logic signed [OUT_BITS-1:0] x_q, y_q;

	// Advance everything when the output slot is free or being taken
	assign en       = !ov_q || !out_stall;
	assign in_stall = !en;

	segx_front #(.C(C), .DW(DW), .NW(NW)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(in_valid),
		.ax0     (a_start_x),
		.ay0     (a_start_y),
		.ax1     (a_end_x),
		.ay1     (a_end_y),
		.bx0     (b_start_x),
		.by0     (b_start_y),
		.bx1     (b_end_x),
		.by1     (b_end_y),
		.ctl     (ctl_f),
		.det_mag (det_mag),
		.nx_mag  (nx_mag),
		.nx_neg  (nx_neg),
		.ny_mag  (ny_mag),
		.ny_neg  (ny_neg)
	);

	segx_div #(.C(C), .F(FRAC_BITS), .DW(DW), .NW(NW), .QB(QB)) u_div_x (
		.clk    (clk),
		.en     (en),
		.m      (nx_mag),
		.neg_in (nx_neg),
		.d      (det_mag),
		.q      (qx),
		.neg_out(qx_neg)
	);

	segx_div #(.C(C), .F(FRAC_BITS), .DW(DW), .NW(NW), .QB(QB)) u_div_y (
		.clk    (clk),
		.en     (en),
		.m      (ny_mag),
		.neg_in (ny_neg),
		.d      (det_mag),
		.q      (qy),
		.neg_out(qy_neg)
	);

	// Carry valid and status alongside the divider stages
	assign ctl_s[0] = ctl_f;
	for (genvar k = 0; k < QB; k++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k+1] <= '{valid: 1'b0, status: ST_HIT};
			end else if (en) begin
				ctl_s[k+1] <= ctl_s[k];
			end
		end
	end

	// Restore the sign: truncation toward zero
	assign sx = qx_neg ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
	assign sy = qy_neg ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

	// Output register; zero the point unless it is a hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			st_q <= ST_HIT;
		end else if (en) begin
			ov_q <= ctl_s[QB].valid;
			st_q <= ctl_s[QB].status;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q <= (ctl_s[QB].status == ST_HIT) ? OUT_BITS'(sx) : '0;
			y_q <= (ctl_s[QB].status == ST_HIT) ? OUT_BITS'(sy) : '0;
		end
	end

	assign out_valid = ov_q;
	assign status    = st_q;
	assign cross_x   = x_q;
	assign cross_y   = y_q;

endmodule

`default_nettype wire

// ===== sim/segment_intersection_test.sv =====
`timescale 1ns / 1ps

module segment_intersection_test;
	import segx_pkg::*;

	localparam int CB = 12;
	localparam int FB = 12;
	localparam int LATENCY = 7 + CB + FB;

	typedef logic signed [CB-1:0] coord_t;
	typedef logic signed [OUT_BITS-1:0] fix_t;

	typedef struct {
		coord_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
	} seg_pair_t;

	typedef struct packed {
		status_t st;
		fix_t x;
		fix_t y;
	} crossing_t;

	// directed row: known marks whether the typed-in result is used
	typedef struct {
		seg_pair_t p;
		bit known;
		crossing_t r;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	coord_t a_start_x = 0, a_start_y = 0, a_end_x = 0, a_end_y = 0;
	coord_t b_start_x = 0, b_start_y = 0, b_end_x = 0, b_end_y = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [1:0] status;
	fix_t cross_x, cross_y;

	crossing_t pending_crossings[$];
	int errors = 0;
	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	bit hold_sink = 0;

	segment_intersection #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.a_start_x(a_start_x), .a_start_y(a_start_y),
		.a_end_x(a_end_x), .a_end_y(a_end_y),
		.b_start_x(b_start_x), .b_start_y(b_start_y),
		.b_end_x(b_end_x), .b_end_y(b_end_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .cross_x(cross_x), .cross_y(cross_y)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// exact crossing of two segments, fixed point truncated toward zero
	function automatic crossing_t predict_crossing(seg_pair_t p);
		longint rx, ry, sx, sy, ex, ey, det, tn, un, nx, ny;
		crossing_t r;
		r.st = ST_HIT;
		r.x = 0;
		r.y = 0;
		rx = longint'(p.ax1) - p.ax0;
		ry = longint'(p.ay1) - p.ay0;
		sx = longint'(p.bx1) - p.bx0;
		sy = longint'(p.by1) - p.by0;
		ex = longint'(p.bx0) - p.ax0;
		ey = longint'(p.by0) - p.ay0;
		det = rx * sy - ry * sx;
		if (det == 0) begin
			r.st = ST_PARALLEL;
			return r;
		end
		tn = ex * sy - ey * sx;
		un = ex * ry - ey * rx;
		if (det < 0) begin
			det = -det;
			tn = -tn;
			un = -un;
		end
		if (tn < 0 || tn > det || un < 0 || un > det) begin
			r.st = ST_OUTSIDE;
			return r;
		end
		nx = (longint'(p.ax0) * det + tn * rx) * (longint'(1) << FB);
		ny = (longint'(p.ay0) * det + tn * ry) * (longint'(1) << FB);
		r.x = fix_t'(nx / det);
		r.y = fix_t'(ny / det);
		return r;
	endfunction

	function automatic seg_pair_t mk(int a0, int a1, int a2, int a3,
			int b0, int b1, int b2, int b3);
		seg_pair_t p;
		p.ax0 = coord_t'(a0); p.ay0 = coord_t'(a1);
		p.ax1 = coord_t'(a2); p.ay1 = coord_t'(a3);
		p.bx0 = coord_t'(b0); p.by0 = coord_t'(b1);
		p.bx1 = coord_t'(b2); p.by1 = coord_t'(b3);
		return p;
	endfunction

	function automatic coord_t rnd_coord(int span);
		if (span >= 2048)
			return coord_t'($urandom);
		return coord_t'($urandom_range(2 * span) - span);
	endfunction

	// mostly crossing candidates: a point on each segment near a shared spot
	function automatic seg_pair_t rnd_pair();
		int mode, span, cx, cy;
		seg_pair_t p;
		mode = $urandom_range(9);
		span = ($urandom_range(3) == 0) ? 2048 : $urandom_range(1, 300);
		if (mode < 6) begin
			cx = rnd_coord(1700);
			cy = rnd_coord(1700);
			p.ax0 = coord_t'(cx + rnd_coord(span > 340 ? 340 : span));
			p.ay0 = coord_t'(cy + rnd_coord(span > 340 ? 340 : span));
			p.ax1 = coord_t'(2 * cx - p.ax0);
			p.ay1 = coord_t'(2 * cy - p.ay0);
			p.bx0 = coord_t'(cx + rnd_coord(span > 340 ? 340 : span));
			p.by0 = coord_t'(cy + rnd_coord(span > 340 ? 340 : span));
			p.bx1 = coord_t'(2 * cx - p.bx0 + rnd_coord(3));
			p.by1 = coord_t'(2 * cy - p.by0 + rnd_coord(3));
		end else if (mode == 6) begin
			// parallel copies
			p.ax0 = rnd_coord(1000); p.ay0 = rnd_coord(1000);
			p.ax1 = p.ax0 + rnd_coord(500); p.ay1 = p.ay0 + rnd_coord(500);
			p.bx0 = rnd_coord(1000); p.by0 = rnd_coord(1000);
			p.bx1 = p.bx0 + (p.ax1 - p.ax0); p.by1 = p.by0 + (p.ay1 - p.ay0);
		end else begin
			p = mk($urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom);
		end
		return p;
	endfunction

	task automatic send_pair(seg_pair_t p);
		// drop valid for each idle cycle so an accepted beat is never offered again
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		a_start_x <= p.ax0; a_start_y <= p.ay0; a_end_x <= p.ax1; a_end_y <= p.ay1;
		b_start_x <= p.bx0; b_start_y <= p.by0; b_end_x <= p.bx1; b_end_y <= p.by1;
		do
			@(posedge clk);
		while (in_stall);
		pending_crossings.push_back(predict_crossing(p));
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending_crossings.size() != 0)
			@(posedge clk);
	endtask

	// sink: random stall, or a long hold when asked
	always @(posedge clk) begin
		out_stall <= hold_sink || ($urandom_range(99) < snk_stall_pct);
	end

	// compare each accepted result beat with the oldest prediction
	always @(posedge clk) begin
		crossing_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_crossings.size() == 0) begin
				$error("unexpected result beat status=%0d", status);
				errors++;
			end else begin
				e = pending_crossings.pop_front();
				if (status !== e.st) begin
					$error("status expected %0d got %0d", e.st, status);
					errors++;
				end
				if (cross_x !== e.x) begin
					$error("cross_x expected %0d got %0d", e.x, cross_x);
					errors++;
				end
				if (cross_y !== e.y) begin
					$error("cross_y expected %0d got %0d", e.y, cross_y);
					errors++;
				end
			end
		end
	end

	initial begin
		#50ms;
		$display("segment_intersection_test failed");
		$finish;
	end

	initial begin
		row_t rows[$];
		row_t rw;
		crossing_t exp_r;
		int n;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed rows; results typed in where obvious
		rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0), 1, '{ST_PARALLEL, 0, 0}});
		rows.push_back('{mk(-2048, -2048, 2047, 2047, -2048, 2047, 2047, -2048),
			0, '{ST_HIT, 0, 0}});
		rows.push_back('{mk(0, 0, 4, 4, 0, 4, 4, 0), 1, '{ST_HIT, 2 << FB, 2 << FB}});
		rows.push_back('{mk(0, 0, 2, 0, 2, 0, 2, 5), 1, '{ST_HIT, 2 << FB, 0}});
		rows.push_back('{mk(0, 0, 1, 0, 3, -1, 3, 1), 1, '{ST_OUTSIDE, 0, 0}});
		rows.push_back('{mk(0, 0, 4, 0, 2, 0, 6, 0), 1, '{ST_PARALLEL, 0, 0}});
		rows.push_back('{mk(0, 0, 4, 0, 0, 1, 4, 1), 1, '{ST_PARALLEL, 0, 0}});
		rows.push_back('{mk(0, 0, 0, 0, -1, -1, 1, 1), 1, '{ST_PARALLEL, 0, 0}});
		rows.push_back('{mk(0, 0, 3, 1, 0, 1, 3, 0), 0, '{ST_HIT, 0, 0}});
		rows.push_back('{mk(0, 0, -3, -1, 0, -1, -3, 0), 0, '{ST_HIT, 0, 0}});
		rows.push_back('{mk(2047, 2047, 2047, -2048, -2048, 2047, 2047, 2047), 1,
			'{ST_HIT, 2047 << FB, 2047 << FB}});
		rows.push_back('{mk(-2048, -2048, -2048, 2047, -2048, -2048, 2047, -2048), 1,
			'{ST_HIT, -2048 << FB, -2048 << FB}});
		rows.push_back('{mk(-2048, 0, 2047, 1, 0, -2048, 1, 2047), 0, '{ST_HIT, 0, 0}});
		rows.push_back('{mk(0, 0, 1, 0, 0, 1, 1, 2), 1, '{ST_OUTSIDE, 0, 0}});
		rows.push_back('{mk(1, 1, -1, -2, -1, 1, 1, -1), 0, '{ST_HIT, 0, 0}});
		rows.push_back('{mk(0, 0, 1, 0, 0, 0, 0, 1), 1, '{ST_HIT, 0, 0}});
		foreach (rows[i]) begin
			rw = rows[i];
			exp_r = predict_crossing(rw.p);
			if (rw.known && exp_r != rw.r) begin
				$error("directed row %0d table disagrees with predictor", i);
				errors++;
			end
			send_pair(rw.p);
		end
		drain();

		// random phases: none, sender idle, receiver stall, both
		n = 0;
		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 74 : 8) : 0;
			snk_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 74 : 8) : 0;
			for (int k = 0; k < 130; k++)
				send_pair(rnd_pair());
			// sender pauses until everything is back
			drain();
		end

		// long receiver hold while the sender keeps offering beats
		src_idle_pct = 0;
		snk_stall_pct = 0;
		hold_sink = 1;
		fork
			begin
				repeat (3 * LATENCY) @(posedge clk);
				hold_sink = 0;
			end
			for (int k = 0; k < 40; k++)
				send_pair(rnd_pair());
		join
		drain();

		repeat (LATENCY + 5) @(posedge clk);
		if (errors == 0)
			$display("segment_intersection_test passed");
		else
			$display("segment_intersection_test failed");
		$finish;
	end

endmodule
